// ===== hdl/sha1_pkg.sv =====
package sha1_pkg;

  localparam int BLOCK_WORDS  = 16;
  localparam int ROUNDS       = 80;
  localparam int DIGEST_WORDS = 5;

  localparam logic [31:0] IV_WORDS [0:DIGEST_WORDS-1] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_CH   = 32'h5A827999;
  localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
  localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Working variables of one compression.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  // Round group, which selects the mixing function and the additive constant.
  typedef enum logic [1:0] {
    PH_CH   = 2'd0,
    PH_PAR1 = 2'd1,
    PH_MAJ  = 2'd2,
    PH_PAR2 = 2'd3
  } phase_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

endpackage

// ===== hdl/sha1_round.sv =====
module sha1_round (
  input  sha1_pkg::work_t  cur,
  input  logic [31:0]      w,
  input  sha1_pkg::phase_t phase,
  output sha1_pkg::work_t  nxt
);
  import sha1_pkg::*;

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    unique case (phase)
      PH_CH: begin
        f = (cur.b & cur.c) | (~cur.b & cur.d);
        k = K_CH;
      end
      PH_PAR1: begin
        f = cur.b ^ cur.c ^ cur.d;
        k = K_PAR1;
      end
      PH_MAJ: begin
        f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
        k = K_MAJ;
      end
      default: begin
        f = cur.b ^ cur.c ^ cur.d;
        k = K_PAR2;
      end
    endcase
  end

  always_comb begin
    nxt.a = rotl(cur.a, 5) + f + cur.e + k + w;
    nxt.b = cur.a;
    nxt.c = rotl(cur.b, 30);
    nxt.d = cur.c;
    nxt.e = cur.d;
  end

endmodule

// ===== hdl/sha1_hash_engine.sv =====
// Channel  | Handshake               | Payload
// ---------+-------------------------+-------------------------------------
// message  | msg_valid / msg_stall   | data_byte, byte_valid, message_end
// digest   | digest_valid / digest_stall | digest_word, word_index, last_word
//
// A message byte goes through a read of its block word, then the merged write.
// A full block then goes through a prefetch, the rounds and a chaining add.
// After the last item the pad bytes go through the same path, each through S_NEXT, S_RD and S_WR.
// The digest is five beats, one per cycle unless digest_stall holds them.
// Reset (rst, synchronous) loads the initial chaining values; the block buffer
// is not cleared, since every byte of a block is written before the block is compressed.
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        message_end,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_RD    = 8'b00000010,
    S_WR    = 8'b00000100,
    S_NEXT  = 8'b00001000,
    S_CPRE  = 8'b00010000,
    S_ROUND = 8'b00100000,
    S_CADD  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t      state;
  state_t      take_state;
  logic [5:0]  fill;
  logic [60:0] msg_bytes;
  logic        pad_mode;
  logic        sent80;
  logic [3:0]  len_cnt;
  logic [63:0] len_bits;
  logic [7:0]  cur_byte;
  logic [6:0]  rcnt;
  logic [6:0]  rnext;
  logic [2:0]  out_cnt;
  logic [31:0] chain [0:DIGEST_WORDS-1];
  logic [31:0] win [0:BLOCK_WORDS-1];
  work_t       work;
  work_t       work_next;
  phase_t      phase;
  logic [31:0] w_t;

  logic [31:0] blk_mem [0:BLOCK_WORDS-1];
  logic [3:0]  mem_raddr;
  logic [31:0] mem_rdata;
  logic [31:0] merged;
  logic        mem_we;

  logic msg_ready;
  logic take;
  logic dig_take;

  assign msg_ready = (state == S_IDLE) || (state == S_WR && !pad_mode && fill != 6'd63);
  assign msg_stall = !msg_ready;
  assign take      = msg_valid && msg_ready;

  assign digest_valid = (state == S_OUT);
  assign digest_word  = chain[out_cnt];
  assign word_index   = out_cnt;
  assign last_word    = (out_cnt == 3'(DIGEST_WORDS - 1));
  assign dig_take     = digest_valid && !digest_stall;

  assign rnext  = 7'(rcnt + 7'd1);
  assign mem_we = (state == S_WR);

  // State that an accepted beat leads to.
  always_comb begin
    if (byte_valid) begin
      take_state = S_RD;
    end else if (message_end) begin
      take_state = S_NEXT;
    end else begin
      take_state = S_IDLE;
    end
  end

  always_comb begin
    unique case (state)
      S_RD:    mem_raddr = fill[5:2];
      S_ROUND: mem_raddr = rnext[3:0];
      default: mem_raddr = 4'd0;
    endcase
  end

  // Byte lane 0 is the most significant byte of the word.
  always_comb begin
    unique case (fill[1:0])
      2'd0:    merged = {cur_byte, mem_rdata[23:0]};
      2'd1:    merged = {mem_rdata[31:24], cur_byte, mem_rdata[15:0]};
      2'd2:    merged = {mem_rdata[31:16], cur_byte, mem_rdata[7:0]};
      default: merged = {mem_rdata[31:8], cur_byte};
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem[fill[5:2]] <= merged;
    end
    mem_rdata <= blk_mem[mem_raddr];
  end

  always_comb begin
    if (rcnt < 7'd20) begin
      phase = PH_CH;
    end else if (rcnt < 7'd40) begin
      phase = PH_PAR1;
    end else if (rcnt < 7'd60) begin
      phase = PH_MAJ;
    end else begin
      phase = PH_PAR2;
    end
  end

  // The first sixteen schedule words come from the buffer, the rest from the window.
  assign w_t = (rcnt < 7'(BLOCK_WORDS)) ? mem_rdata
             : rotl(win[13] ^ win[8] ^ win[2] ^ win[0], 1);

  sha1_round u_round (
    .cur   (work),
    .w     (w_t),
    .phase (phase),
    .nxt   (work_next)
  );

  always_ff @(posedge clk) begin
    if (state == S_ROUND) begin
      for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
        win[j] <= win[j+1];
      end
      win[BLOCK_WORDS-1] <= w_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      msg_bytes <= '0;
      pad_mode  <= 1'b0;
      sent80    <= 1'b0;
      len_cnt   <= '0;
      rcnt      <= '0;
      out_cnt   <= '0;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain[i] <= IV_WORDS[i];
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            state <= take_state;
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (fill == 6'd63) begin
            fill  <= '0;
            state <= S_CPRE;
          end else begin
            fill  <= 6'(fill + 6'd1);
            state <= take ? take_state : (pad_mode ? S_NEXT : S_IDLE);
          end
        end
        S_NEXT: begin
          if (!sent80) begin
            cur_byte <= PAD_BYTE;
            sent80   <= 1'b1;
            state    <= S_RD;
          end else if (len_cnt == 4'd0 && fill != 6'd56) begin
            cur_byte <= 8'd0;
            state    <= S_RD;
          end else if (len_cnt != 4'd8) begin
            cur_byte <= len_bits[63:56];
            len_bits <= len_bits << 8;
            len_cnt  <= 4'(len_cnt + 4'd1);
            state    <= S_RD;
          end else begin
            out_cnt <= '0;
            state   <= S_OUT;
          end
        end
        S_CPRE: begin
          work  <= '{a: chain[0], b: chain[1], c: chain[2], d: chain[3], e: chain[4]};
          rcnt  <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          work <= work_next;
          if (rcnt == 7'(ROUNDS - 1)) begin
            state <= S_CADD;
          end else begin
            rcnt <= rnext;
          end
        end
        S_CADD: begin
          chain[0] <= chain[0] + work.a;
          chain[1] <= chain[1] + work.b;
          chain[2] <= chain[2] + work.c;
          chain[3] <= chain[3] + work.d;
          chain[4] <= chain[4] + work.e;
          state    <= pad_mode ? S_NEXT : S_IDLE;
        end
        default: begin
          if (dig_take) begin
            if (last_word) begin
              for (int i = 0; i < DIGEST_WORDS; i++) begin
                chain[i] <= IV_WORDS[i];
              end
              fill      <= '0;
              msg_bytes <= '0;
              pad_mode  <= 1'b0;
              state     <= S_IDLE;
            end else begin
              out_cnt <= 3'(out_cnt + 3'd1);
            end
          end
        end
      endcase

      // An accepted beat loads its byte; the closing beat also starts the padding.
      if (take) begin
        if (byte_valid) begin
          cur_byte  <= data_byte;
          msg_bytes <= 61'(msg_bytes + 61'd1);
        end
        if (message_end) begin
          pad_mode <= 1'b1;
          sent80   <= 1'b0;
          len_cnt  <= '0;
          len_bits <= byte_valid ? {61'(msg_bytes + 61'd1), 3'b000} : {msg_bytes, 3'b000};
        end
      end
    end
  end

  a_no_intake_during_digest: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> msg_stall)
    else $error("message beat could be taken while the digest is out");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (dig_take && last_word) |=> (!digest_valid && fill == 6'd0 && msg_bytes == 61'd0))
    else $error("state not reloaded after the last digest word");

  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (rcnt < 7'(ROUNDS)))
    else $error("round counter ran past the last round");

  a_end_starts_pad: assert property (@(posedge clk) disable iff (rst)
    (take && message_end) |=> pad_mode)
    else $error("closing beat did not start padding");

  a_full_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_CPRE) |-> (fill == 6'd0 && $past(fill) == 6'd63))
    else $error("compression started on a partial block");

endmodule
